@@ src/tof_ranging_result_postprocess_defines.svh @@
// assertion macros shared by the ranging post-processor
`ifndef TOF_RANGING_RESULT_POSTPROCESS_DEFINES_SVH
`define TOF_RANGING_RESULT_POSTPROCESS_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define TOFRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define TOFRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOFRR_ASSERT(label, prop, msg)
`define TOFRR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/tofrr_pkg.sv @@
package tofrr_pkg;

  // divider word width and number of cells per divider
  localparam int DIV_W = 32;
  // input register + two cell rows + middle register + output register
  localparam int LATENCY = 2 * DIV_W + 3;

  localparam logic [10:0] RANGE_SCALE   = 11'd2011;
  localparam logic [26:0] RANGE_ROUND   = 27'h0000400;
  localparam logic [15:0] SAT16         = 16'hFFFF;
  localparam logic [15:0] SPAD_FALLBACK = 16'h8000;
  localparam logic [15:0] TARGET_RST    = 16'd2560;

  // raw status codes from the ranging core
  localparam logic [7:0] RAW_HW_A        = 8'd1;
  localparam logic [7:0] RAW_HW_B        = 8'd2;
  localparam logic [7:0] RAW_HW_C        = 8'd3;
  localparam logic [7:0] RAW_SIGNAL_FAIL = 8'd4;
  localparam logic [7:0] RAW_BOUNDS_FAIL = 8'd5;
  localparam logic [7:0] RAW_SIGMA_FAIL  = 8'd6;
  localparam logic [7:0] RAW_WRAP_FAIL   = 8'd7;
  localparam logic [7:0] RAW_MIN_CLIP    = 8'd8;
  localparam logic [7:0] RAW_RANGE_OK    = 8'd9;
  localparam logic [7:0] RAW_XTALK_FAIL  = 8'd12;
  localparam logic [7:0] RAW_MIN_RANGE   = 8'd13;
  localparam logic [7:0] RAW_HW_D        = 8'd17;
  localparam logic [7:0] RAW_SYNC_FAIL   = 8'd18;

  typedef enum logic [3:0] {
    ST_VALID       = 4'd0,
    ST_SIGMA       = 4'd1,
    ST_SIGNAL      = 4'd2,
    ST_MIN_CLIPPED = 4'd3,
    ST_BOUNDS      = 4'd4,
    ST_HARDWARE    = 4'd5,
    ST_NO_WRAP     = 4'd6,
    ST_WRAP        = 4'd7,
    ST_XTALK       = 4'd8,
    ST_SYNC        = 4'd9,
    ST_MIN_RANGE   = 4'd10,
    ST_NONE        = 4'd11
  } status_t;

  typedef struct packed {
    logic [7:0]  raw_status;
    logic [7:0]  meas_count;
    logic [15:0] effective_spads;
    logic [15:0] ambient_rate;
    logic [15:0] measured_range;
    logic [15:0] peak_rate;
  } in_req_t;

  typedef struct packed {
    logic [15:0] dist_mm;
    logic [3:0]  status_code;
    logic [15:0] spad_select;
  } out_res_t;

  // fields that ride along the divider cells unchanged
  typedef struct packed {
    logic [15:0] dist_mm;
    logic [3:0]  status_code;
    logic [15:0] target_rate;
    logic        fallback;
  } side_t;

  // one divider cell's state
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] divisor;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dq;
    side_t            side;
  } div_t;

  function automatic status_t map_status(logic [7:0] raw, logic [7:0] stream);
    status_t st;
    st = ST_NONE;
    case (raw)
      RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: st = ST_HARDWARE;
      RAW_SIGNAL_FAIL: st = ST_SIGNAL;
      RAW_BOUNDS_FAIL: st = ST_BOUNDS;
      RAW_SIGMA_FAIL:  st = ST_SIGMA;
      RAW_WRAP_FAIL:   st = ST_WRAP;
      RAW_MIN_CLIP:    st = ST_MIN_CLIPPED;
      RAW_RANGE_OK:    st = (stream == 8'd0) ? ST_NO_WRAP : ST_VALID;
      RAW_XTALK_FAIL:  st = ST_XTALK;
      RAW_MIN_RANGE:   st = ST_MIN_RANGE;
      RAW_SYNC_FAIL:   st = ST_SYNC;
      default:         st = ST_NONE;
    endcase
    return st;
  endfunction

endpackage

@@ src/tofrr_div_cell.sv @@
module tofrr_div_cell import tofrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  div_t cell_i,
  output div_t cell_o
);

  logic             valid_r;
  div_t             data_r;
  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;
  logic             ge;
  div_t             data_nxt;

  // one restoring step: bring down next dividend bit, try subtract
  always_comb begin
    shifted  = {cell_i.rem, cell_i.dq[DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, cell_i.divisor};
    ge       = ~trial[DIV_W+1];
    data_nxt = cell_i;
    data_nxt.rem = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    data_nxt.dq  = {cell_i.dq[DIV_W-2:0], ge};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_comb begin
    cell_o       = data_r;
    cell_o.valid = valid_r;
  end

endmodule

@@ src/tofrr_div_chain.sv @@
module tofrr_div_chain import tofrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  div_t div_i,
  output div_t div_o
);

  div_t link [DIV_W+1];

  assign link[0] = div_i;

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    tofrr_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  assign div_o = link[DIV_W];

endmodule

@@ src/tof_ranging_result_postprocess.sv @@
// Time-of-flight ranging result post-processor.
// Input: a request is taken on the rising edge where start is high and busy
// is low; in_req carries one raw result record. busy is high only in reset
// and the cycle after it, so a new request can be taken in every cycle.
// Output: each request gives one result on out_res, marked by out_valid for
// exactly one cycle, in request order. The receiver cannot stall; results
// leave the pipeline at the rate they entered.
// Pipeline: the accepting edge loads the input register; the request then
// passes two rows of 32 restoring divider cells, the middle register and the
// output register. Throughput: one request per cycle outside reset.
// The first row divides the summed rate by the SPAD count, the second
// divides the target rate by that quotient; each cell makes one quotient bit.
// Configuration: cfg_data is written to the target rate register when
// cfg_valid is high (cfg_ready is always high). Each request samples the
// target rate as it is taken. Write only with no request in flight.
// Reset (synchronous, rst_n low) empties the pipeline and sets the target
// rate to 2560.
`include "tof_ranging_result_postprocess_defines.svh"

module tof_ranging_result_postprocess import tofrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        busy_r;
  logic [15:0] target_r;
  logic        accept;
  logic [26:0] scaled;
  logic [16:0] rate_sum;
  logic [15:0] rate_sat;
  div_t        s0_nxt;
  div_t        s0_r;
  logic        s0_valid_r;
  div_t        s0;
  div_t        c1;
  div_t        mid_nxt;
  div_t        mid_r;
  logic        mid_valid_r;
  div_t        mid;
  div_t        c2;
  out_res_t    out_res_nxt;
  out_res_t    out_res_r;
  logic        out_valid_r;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // target rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      target_r <= cfg_data;
    end
  end

  // range scaling, status map, rate sum and first dividend
  always_comb begin
    scaled   = ({11'd0, in_req.measured_range} * {16'd0, RANGE_SCALE}) + RANGE_ROUND;
    rate_sum = {1'b0, in_req.peak_rate} + {1'b0, in_req.ambient_rate};
    rate_sat = rate_sum[16] ? SAT16 : rate_sum[15:0];
    s0_nxt.valid            = accept;
    s0_nxt.divisor          = {16'd0, in_req.effective_spads};
    s0_nxt.rem              = '0;
    s0_nxt.dq               = {rate_sat, 16'd0};
    s0_nxt.side.dist_mm     = scaled[26:11];
    s0_nxt.side.status_code = map_status(in_req.raw_status, in_req.meas_count);
    s0_nxt.side.target_rate = target_r;
    s0_nxt.side.fallback    = (in_req.effective_spads == 16'd0);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  always_comb begin
    s0       = s0_r;
    s0.valid = s0_valid_r;
  end

  // per-SPAD rate
  tofrr_div_chain u_div_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .div_i (s0),
    .div_o (c1)
  );

  // second dividend and divisor
  always_comb begin
    mid_nxt               = c1;
    mid_nxt.divisor       = c1.dq;
    mid_nxt.rem           = '0;
    mid_nxt.dq            = {c1.side.target_rate, 16'd0};
    mid_nxt.side.fallback = c1.side.fallback | (c1.dq == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else begin
      mid_valid_r <= c1.valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  always_comb begin
    mid       = mid_r;
    mid.valid = mid_valid_r;
  end

  // required SPAD count
  tofrr_div_chain u_div_spad (
    .clk   (clk),
    .rst_n (rst_n),
    .div_i (mid),
    .div_o (c2)
  );

  // saturate and pick fallback
  always_comb begin
    out_res_nxt.dist_mm     = c2.side.dist_mm;
    out_res_nxt.status_code = c2.side.status_code;
    if (c2.side.fallback) begin
      out_res_nxt.spad_select = SPAD_FALLBACK;
    end else if (c2.dq[DIV_W-1:16] != '0) begin
      out_res_nxt.spad_select = SAT16;
    end else begin
      out_res_nxt.spad_select = c2.dq[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c2.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // checks
  `TOFRR_ASSERT(a_latency, out_valid |-> $past(start && !busy, LATENCY),
                "result without request")
  `TOFRR_ASSERT(a_zero_spads,
                (start && !busy && in_req.effective_spads == 16'd0) |->
                  ##LATENCY (out_valid && out_res.spad_select == SPAD_FALLBACK),
                "zero SPAD count not on fallback")
  `TOFRR_ASSERT(a_zero_rate,
                (start && !busy && in_req.peak_rate == 16'd0 &&
                 in_req.ambient_rate == 16'd0) |->
                  ##LATENCY (out_valid && out_res.spad_select == SPAD_FALLBACK),
                "zero rate not on fallback")
  `TOFRR_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> (busy && !out_valid),
                       "pipeline not held in reset")

endmodule
